FILE: src/ndc_pkg.sv
// Shared types and constants for the non-negative linear Diophantine checker.
// Used by every module of the block; depends on nothing else.
package ndc_pkg;

    localparam int OPND_W = 16;                 // width of coefficients and target
    localparam int COEF_W = OPND_W + 2;         // signed Bezout coefficient width
    localparam int PROD_W = 2 * COEF_W;         // shared multiplier product width
    localparam int DVD_W  = 2 * OPND_W;         // widest dividend of the divider
    localparam int CNT_W  = $clog2(DVD_W + 1);  // divider step counter width
    localparam int IN_W   = 3 * OPND_W;
    localparam int OUT_W  = ((OPND_W + 1 + 7) / 8) * 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EUC_CHK,
        ST_EUC_DIV,
        ST_EUC_MUL,
        ST_EUC_UPD,
        ST_GCD_DONE,
        ST_CG_DIV,
        ST_BG_START,
        ST_BG_DIV,
        ST_SMOD,
        ST_CM_DIV,
        ST_PM_MUL,
        ST_PM_START,
        ST_PM_DIV,
        ST_AX_MUL,
        ST_AX_CMP
    } state_t;

    typedef struct packed {
        logic [OPND_W-1:0] target_sum;
        logic [OPND_W-1:0] coef_b;
        logic [OPND_W-1:0] coef_a;
    } req_t;

    typedef struct packed {
        logic [OPND_W-1:0] common_divisor;
        logic              feasible;
    } res_t;

    typedef struct packed {
        logic              start;
        logic              long_op;
        logic [DVD_W-1:0]  dividend;
        logic [OPND_W-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic              done;
        logic [DVD_W-1:0]  quot;
        logic [OPND_W-1:0] rem;
    } div_rsp_t;

endpackage

FILE: src/ndc_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Short requests divide OPND_W bits, long ones DVD_W bits. Depends on ndc_pkg.
module ndc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ndc_pkg::div_cmd_t cmd,
    output ndc_pkg::div_rsp_t rsp
);
    import ndc_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [OPND_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [OPND_W-1:0] dsr_reg, dsr_next;
    logic [OPND_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        if (cmd.start)
        begin
            busy_next = 1'b1;
            rem_next  = '0;
            dsr_next  = cmd.divisor;
            if (cmd.long_op)
            begin
                quo_next = cmd.dividend;
                cnt_next = CNT_W'(DVD_W);
            end
            else
            begin
                // The short dividend sits in the upper half so it shifts out first.
                quo_next = {cmd.dividend[OPND_W-1:0], {(DVD_W-OPND_W){1'b0}}};
                cnt_next = CNT_W'(OPND_W);
            end
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = OPND_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[OPND_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

FILE: src/ndc_mul.sv
// Shared signed multiplier with a registered product.
// The product is valid in the cycle after the operands. Depends on ndc_pkg.
module ndc_mul (
    input  logic                                clk,
    input  logic signed [ndc_pkg::COEF_W-1:0]   op_a,
    input  logic signed [ndc_pkg::COEF_W-1:0]   op_b,
    output logic signed [ndc_pkg::PROD_W-1:0]   prod
);
    import ndc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

FILE: src/ndc_seq.sv
// Sequencer for the checker: extended Euclid, divisibility test and the
// smallest non-negative x, all through the shared divider and multiplier.
// Depends on ndc_pkg, ndc_div and ndc_mul.
module ndc_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ndc_pkg::req_t req,
    output logic          res_valid,
    input  logic          res_ready,
    output ndc_pkg::res_t res
);
    import ndc_pkg::*;

    state_t state_reg, state_next;

    logic [OPND_W-1:0] a_reg, a_next;
    logic [OPND_W-1:0] b_reg, b_next;
    logic [OPND_W-1:0] c_reg, c_next;
    logic [OPND_W-1:0] r0_reg, r0_next;
    logic [OPND_W-1:0] r1_reg, r1_next;
    logic [OPND_W-1:0] q_reg, q_next;
    logic signed [COEF_W-1:0] s0_reg, s0_next;
    logic signed [COEF_W-1:0] s1_reg, s1_next;
    logic [OPND_W-1:0] cq_reg, cq_next;
    logic [OPND_W-1:0] bg_reg, bg_next;
    logic [OPND_W-1:0] su_reg, su_next;
    logic [OPND_W-1:0] cm_reg, cm_next;
    logic [OPND_W-1:0] x0_reg, x0_next;
    logic              feas_reg, feas_next;

    div_cmd_t div_cmd;
    div_rsp_t div_rsp;
    logic signed [COEF_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [COEF_W-1:0] bg_s, v1, v2;

    ndc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

    ndc_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        r0_next    = r0_reg;
        r1_next    = r1_reg;
        q_next     = q_reg;
        s0_next    = s0_reg;
        s1_next    = s1_reg;
        cq_next    = cq_reg;
        bg_next    = bg_reg;
        su_next    = su_reg;
        cm_next    = cm_reg;
        x0_next    = x0_reg;
        feas_next  = feas_reg;
        req_ready  = 1'b0;
        res_valid  = 1'b0;

        div_cmd.start    = 1'b0;
        div_cmd.long_op  = 1'b0;
        div_cmd.dividend = DVD_W'(r0_reg);
        div_cmd.divisor  = r1_reg;

        mul_a = $signed({2'b00, a_reg});
        mul_b = $signed({2'b00, x0_reg});

        // Reduce the Bezout coefficient into [0, b/g); it is known to lie in [-b/g, b/g].
        bg_s = $signed({2'b00, bg_reg});
        v1   = (s0_reg < 0) ? (s0_reg + bg_s) : s0_reg;
        v2   = (v1 >= bg_s) ? (v1 - bg_s) : v1;

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    a_next     = req.coef_a;
                    b_next     = req.coef_b;
                    c_next     = req.target_sum;
                    r0_next    = req.coef_a;
                    r1_next    = req.coef_b;
                    s0_next    = COEF_W'(1);
                    s1_next    = '0;
                    state_next = ST_EUC_CHK;
                end
            end
            ST_EUC_CHK:
            begin
                if (r1_reg == '0)
                begin
                    state_next = ST_GCD_DONE;
                end
                else
                begin
                    div_cmd.start = 1'b1;
                    state_next    = ST_EUC_DIV;
                end
            end
            ST_EUC_DIV:
            begin
                if (div_rsp.done)
                begin
                    q_next     = div_rsp.quot[OPND_W-1:0];
                    r0_next    = r1_reg;
                    r1_next    = div_rsp.rem;
                    state_next = ST_EUC_MUL;
                end
            end
            ST_EUC_MUL:
            begin
                mul_a      = $signed({2'b00, q_reg});
                mul_b      = s1_reg;
                state_next = ST_EUC_UPD;
            end
            ST_EUC_UPD:
            begin
                s0_next    = s1_reg;
                s1_next    = s0_reg - $signed(prod[COEF_W-1:0]);
                state_next = ST_EUC_CHK;
            end
            ST_GCD_DONE:
            begin
                if (r0_reg == '0)
                begin
                    feas_next  = (c_reg == '0);
                    state_next = ST_IDLE;
                    res_valid  = 1'b1;
                    if (!res_ready)
                    begin
                        state_next = ST_GCD_DONE;
                    end
                end
                else
                begin
                    div_cmd.start    = 1'b1;
                    div_cmd.dividend = DVD_W'(c_reg);
                    div_cmd.divisor  = r0_reg;
                    state_next       = ST_CG_DIV;
                end
            end
            ST_CG_DIV:
            begin
                if (div_rsp.done)
                begin
                    cq_next = div_rsp.quot[OPND_W-1:0];
                    if (div_rsp.rem != '0)
                    begin
                        feas_next  = 1'b0;
                        state_next = ST_AX_CMP;
                    end
                    else
                    begin
                        state_next = ST_BG_START;
                    end
                end
            end
            ST_BG_START:
            begin
                div_cmd.start    = 1'b1;
                div_cmd.dividend = DVD_W'(b_reg);
                div_cmd.divisor  = r0_reg;
                state_next       = ST_BG_DIV;
            end
            ST_BG_DIV:
            begin
                if (div_rsp.done)
                begin
                    bg_next = div_rsp.quot[OPND_W-1:0];
                    if (div_rsp.quot[OPND_W-1:0] == '0)
                    begin
                        feas_next  = 1'b1;
                        state_next = ST_AX_CMP;
                    end
                    else
                    begin
                        state_next = ST_SMOD;
                    end
                end
            end
            ST_SMOD:
            begin
                su_next          = v2[OPND_W-1:0];
                div_cmd.start    = 1'b1;
                div_cmd.dividend = DVD_W'(cq_reg);
                div_cmd.divisor  = bg_reg;
                state_next       = ST_CM_DIV;
            end
            ST_CM_DIV:
            begin
                if (div_rsp.done)
                begin
                    cm_next    = div_rsp.rem;
                    state_next = ST_PM_MUL;
                end
            end
            ST_PM_MUL:
            begin
                mul_a      = $signed({2'b00, su_reg});
                mul_b      = $signed({2'b00, cm_reg});
                state_next = ST_PM_START;
            end
            ST_PM_START:
            begin
                div_cmd.start    = 1'b1;
                div_cmd.long_op  = 1'b1;
                div_cmd.dividend = prod[DVD_W-1:0];
                div_cmd.divisor  = bg_reg;
                state_next       = ST_PM_DIV;
            end
            ST_PM_DIV:
            begin
                if (div_rsp.done)
                begin
                    x0_next    = div_rsp.rem;
                    state_next = ST_AX_MUL;
                end
            end
            ST_AX_MUL:
            begin
                feas_next  = 1'b1;
                state_next = ST_AX_CMP;
            end
            ST_AX_CMP:
            begin
                // The product a*x0 is only meaningful when this state follows the multiply.
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A feasible flag that came from the full path is checked against a*x0 <= c.
    logic ax_ok;
    logic chk_ax_reg, chk_ax_next;

    always_comb
    begin
        ax_ok       = (prod[PROD_W-1:OPND_W] == '0) && (prod[OPND_W-1:0] <= c_reg);
        chk_ax_next = chk_ax_reg;
        if (state_reg == ST_AX_MUL)
        begin
            chk_ax_next = 1'b1;
        end
        else if (state_reg == ST_IDLE)
        begin
            chk_ax_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            chk_ax_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            chk_ax_reg <= chk_ax_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        r0_reg   <= r0_next;
        r1_reg   <= r1_next;
        q_reg    <= q_next;
        s0_reg   <= s0_next;
        s1_reg   <= s1_next;
        cq_reg   <= cq_next;
        bg_reg   <= bg_next;
        su_reg   <= su_next;
        cm_reg   <= cm_next;
        x0_reg   <= x0_next;
        feas_reg <= feas_next;
    end

    assign res.common_divisor = r0_reg;
    assign res.feasible = (state_reg == ST_GCD_DONE) ? (c_reg == '0) :
                          (chk_ax_reg ? ax_ok : feas_reg);

endmodule

FILE: src/nonneg_linear_diophantine_check.sv
// Top level of the non-negative linear Diophantine checker: stream ports and
// the output register. Depends on ndc_pkg and ndc_seq.
//
// Usage: a request on the s_ side carries coef_a, coef_b and target_sum. The
// block answers with one result on the m_ side: feasible (non-negative x, y
// with a*x + b*y = c exist) and common_divisor = gcd(a, b).
// One request is worked on at a time; s_tready is high only while idle.
// Each Euclid quotient step is one serial division on the shared divider,
// a multiply and an update. Up to 23 steps occur for 16-bit operands. The
// full tail adds three OPND_W-bit divisions, one DVD_W-bit division, two
// multiplies and a compare. A request is shortest when both coefficients
// are zero.
// The result goes into an output register, so a new request is accepted while
// an earlier result still waits; if the receiver stalls with m_tready low, the
// block holds the next finished result until the register frees.
// Reset (rst_n low, asynchronous) returns to idle and drops m_tvalid.
module nonneg_linear_diophantine_check (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [ndc_pkg::IN_W-1:0]  s_tdata,   // coef_a, coef_b, target_sum
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [ndc_pkg::OUT_W-1:0] m_tdata    // feasible, common_divisor, zero pad
);
    import ndc_pkg::*;

    req_t req;
    res_t res;
    logic res_valid, res_ready;
    logic m_tvalid_reg, m_tvalid_next;
    res_t out_reg;

    assign req = req_t'(s_tdata);

    ndc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_comb
    begin
        res_ready     = !m_tvalid_reg || m_tready;
        m_tvalid_next = m_tvalid_reg;
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'(out_reg);

endmodule

FILE: src/ndc_chk.sv
// Port-level checks for the non-negative linear Diophantine checker.
// Bound to the top level; depends on ndc_pkg.
module ndc_chk (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [ndc_pkg::OUT_W-1:0] m_tdata
);
    import ndc_pkg::*;

    // A stalled result must hold.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Only one request is in work at a time.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // A request never produces its result in the very next cycle.
    a_min_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

    // Padding bits above the result fields stay zero.
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_W-1:OPND_W+1] == '0)
        else $error("padding bits set");

endmodule

bind nonneg_linear_diophantine_check ndc_chk u_ndc_chk (.*);

FILE: tb/sv/tb_nonneg_linear_diophantine_check.sv
// Self-checking testbench for nonneg_linear_diophantine_check. It sends directed
// and random requests through the stream ports and checks every result against
// its own extended-Euclid predictor. It depends on ndc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_nonneg_linear_diophantine_check;
    import ndc_pkg::*;

    // Holds the predicted answer for each accepted request, in order.
    class solvability_scoreboard;
        res_t expected_answers[$];
        int   mismatches = 0;

        function res_t predict_answer(req_t r);
            longint rem_hi, rem_lo, bez_hi, bez_lo, quo, tmp;
            longint a, b, c, g, bg, sm, x0;
            logic   ok;
            res_t   ans;
            a = r.coef_a;
            b = r.coef_b;
            c = r.target_sum;
            rem_hi = a;
            rem_lo = b;
            bez_hi = 1;
            bez_lo = 0;
            while (rem_lo != 0)
            begin
                quo    = rem_hi / rem_lo;
                tmp    = rem_hi - quo * rem_lo;
                rem_hi = rem_lo;
                rem_lo = tmp;
                tmp    = bez_hi - quo * bez_lo;
                bez_hi = bez_lo;
                bez_lo = tmp;
            end
            g = rem_hi;
            if (g == 0)
                ok = (c == 0);
            else if (c % g != 0)
                ok = 1'b0;
            else
            begin
                bg = b / g;
                if (bg == 0)
                    ok = 1'b1;
                else
                begin
                    // Smallest non-negative x on the solution line; y follows from it.
                    sm = bez_hi % bg;
                    if (sm < 0)
                        sm = sm + bg;
                    x0 = (sm * ((c / g) % bg)) % bg;
                    ok = (a * x0 <= c);
                end
            end
            ans.feasible       = ok;
            ans.common_divisor = g[OPND_W-1:0];
            return ans;
        endfunction

        function void note_request(req_t r);
            expected_answers = {expected_answers, predict_answer(r)};
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_answers.size() == 0)
            begin
                $display("%0t: result with no request pending: feasible %0d common_divisor %0d",
                         $time, got.feasible, got.common_divisor);
                mismatches++;
                return;
            end
            want = expected_answers.pop_front();
            if (got.feasible !== want.feasible)
            begin
                $display("%0t: feasible mismatch, expected %0d actual %0d",
                         $time, want.feasible, got.feasible);
                mismatches++;
            end
            if (got.common_divisor !== want.common_divisor)
            begin
                $display("%0t: common_divisor mismatch, expected %0d actual %0d",
                         $time, want.common_divisor, got.common_divisor);
                mismatches++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;

    solvability_scoreboard board;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    nonneg_linear_diophantine_check u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input int unsigned a, input int unsigned b,
                                input int unsigned c);
        req_t r;
        r.coef_a     = a[OPND_W-1:0];
        r.coef_b     = b[OPND_W-1:0];
        r.target_sum = c[OPND_W-1:0];
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_request(r);
        @(negedge clk);
    endtask

    task automatic send_random_request();
        int unsigned pick, a, b, c, x, y, k;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            a = $urandom_range(1, 65535);
            b = $urandom_range(1, 65535);
            c = $urandom_range(0, 65535);
        end
        else if (pick < 55)
        begin
            a = $urandom_range(1, 300);
            b = $urandom_range(1, 300);
            c = $urandom_range(0, 65535);
        end
        else if (pick < 85)
        begin
            // Build a reachable target, sometimes nudged just below it (or to 1 if 0).
            a = $urandom_range(1, 4000);
            b = $urandom_range(1, 4000);
            x = $urandom_range(0, 65535 / a);
            y = $urandom_range(0, (65535 - a * x) / b);
            c = a * x + b * y;
            if ($urandom_range(0, 3) == 0)
                c = (c == 0) ? 1 : c - 1;
        end
        else if (pick < 95)
        begin
            k = $urandom_range(2, 255);
            a = k * $urandom_range(1, 255);
            b = k * $urandom_range(1, 255);
            if ($urandom_range(0, 1) == 0)
                c = k * $urandom_range(0, 255);
            else
                c = $urandom_range(0, 65535);
        end
        else
        begin
            a = $urandom_range(1, 65535);
            b = $urandom_range(1, 65535);
            case ($urandom_range(0, 2))
                0: a = 0;
                1: b = 0;
                default:
                begin
                    a = 0;
                    b = 0;
                end
            endcase
            if (a + b == 0)
                c = $urandom_range(0, 1) ? 0 : $urandom_range(0, 65535);
            else if ($urandom_range(0, 1) == 0)
                c = (a + b) * $urandom_range(0, 65535 / (a + b));
            else
                c = $urandom_range(0, 65535);
        end
        send_request(a, b, c);
    endtask

    // Receiver: decide readiness at each falling edge.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata[$bits(res_t)-1:0]);
    end

    initial
    begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        board         = new();
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        send_idle_pct = 35;
        recv_idle_pct = 72;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Extremes, non-divisible targets, zero coefficients and a long Euclid chain.
        send_request(1, 1, 0);
        send_request(1, 1, 65535);
        send_request(65535, 65535, 65535);
        send_request(65535, 65535, 65534);
        send_request(0, 0, 0);
        send_request(0, 0, 5);
        send_request(0, 7, 21);
        send_request(0, 7, 22);
        send_request(9, 0, 27);
        send_request(9, 0, 28);
        send_request(0, 65535, 65535);
        send_request(65535, 0, 0);
        send_request(65535, 65534, 65533);
        send_request(2, 4, 7);
        send_request(6, 10, 8);
        send_request(6, 10, 16);
        send_request(3, 5, 7);
        send_request(3, 5, 8);
        send_request(46368, 28657, 65535);
        send_request(28657, 46368, 0);
        send_request(1, 65535, 65534);
        send_request(65535, 1, 65535);
        send_request(32768, 16384, 49152);
        send_request(255, 256, 65280);

        repeat (420) send_random_request();
        send_idle_pct = 72;
        recv_idle_pct = 35;
        repeat (440) send_random_request();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (440) send_random_request();
        s_tvalid <= 1'b0;

        while (board.expected_answers.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (board.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
